>>> rtl/viterbi_hard_decision_decoder_assert.svh
// assertion macros for the decoder
`ifndef VITERBI_HARD_DECISION_DECODER_ASSERT_SVH
`define VITERBI_HARD_DECISION_DECODER_ASSERT_SVH

// same-cycle implication
`define VHD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("decoder check failed");

// next-cycle implication
`define VHD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("decoder check failed");

`endif

>>> rtl/vhd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vhd_pkg;

  localparam int GEN_W = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_GEN_ZERO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GEN_ONE  = 2'd1;

  localparam logic [GEN_W-1:0] GEN_ZERO_RESET = 3'd7;
  localparam logic [GEN_W-1:0] GEN_ONE_RESET  = 3'd5;

  localparam logic [63:0] UNREACHABLE_SEED = 64'd1000000;

  typedef struct packed {
    logic code_bit_zero;
    logic code_bit_one;
    logic frame_start;
  } sym_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_TRACE,
    BK_PUSH
  } bk_state_t;

endpackage
`default_nettype wire

>>> rtl/vhd_front.sv
`timescale 1ns / 1ps
`default_nettype none
module vhd_front
  import vhd_pkg::*;
(
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic push,
  output logic       full,
  input  wire  sym_t in_sym,
  output logic       sym_vld,
  output sym_t       sym,
  input  wire  logic sym_pop
);

  sym_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign sym_vld = (count != 2'd0);
  assign sym     = slot[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = sym_pop && sym_vld;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= in_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/vhd_back.sv
`timescale 1ns / 1ps
`default_nettype none
module vhd_back
  import vhd_pkg::*;
#(
  parameter int CONSTRAINT_LENGTH = 3,
  parameter int TRACEBACK_DEPTH   = 6,
  parameter int METRIC_WIDTH      = 16
) (
  input  wire  logic             clk,
  input  wire  logic             rst,
  input  wire  logic [GEN_W-1:0] gen_zero,
  input  wire  logic [GEN_W-1:0] gen_one,
  input  wire  logic             sym_vld,
  input  wire  sym_t             sym,
  output logic                   sym_pop,
  input  wire  logic             res_ready,
  output logic                   res_push,
  output logic                   res_bit
);

  localparam int K     = CONSTRAINT_LENGTH;
  localparam int D     = TRACEBACK_DEPTH;
  localparam int MW    = METRIC_WIDTH;
  localparam int NS    = 1 << (K - 1);
  localparam int SW    = K - 1;
  localparam int CW    = $clog2(D);
  localparam int SumW  = MW + 1;
  localparam int RegMask = (1 << K) - 1;

  localparam logic [CW-1:0] LastCol = CW'(D - 1);
  localparam logic [63:0]   MaxFull = (64'd1 << MW) - 64'd1;
  localparam logic [63:0]   FarWide = (UNREACHABLE_SEED < MaxFull) ? UNREACHABLE_SEED : MaxFull;
  localparam logic [MW-1:0] Far     = FarWide[MW-1:0];

  bk_state_t      state;
  bk_state_t      state_next;
  logic [MW-1:0]  pm [NS];
  logic [MW-1:0]  pm_in [NS];
  logic [MW-1:0]  pm_new [NS];
  logic [NS-1:0]  surv_col;
  logic [NS-1:0]  surv_mem [D];
  logic [NS-1:0]  surv_rd;
  logic [CW-1:0]  wr_slot;
  logic [CW-1:0]  wr_slot_next;
  logic [CW-1:0]  seen;
  logic [CW-1:0]  seen_next;
  logic [CW-1:0]  col;
  logic [CW-1:0]  col_next;
  logic [CW-1:0]  step;
  logic [CW-1:0]  step_next;
  logic [SW-1:0]  tbs;
  logic [SW-1:0]  tbs_next;
  logic           res;
  logic           res_next;
  logic [CW-1:0]  wr_base;
  logic [CW-1:0]  seen_base;
  logic           start;

  // add-compare-select, all states at once
  for (genvar s = 0; s < NS; s++) begin : g_acs
    localparam int P0 = s >> 1;
    localparam int P1 = P0 + NS / 2;
    localparam int R0 = ((P0 << 1) | (s & 1)) & RegMask;
    localparam int R1 = ((P1 << 1) | (s & 1)) & RegMask;
    localparam logic [GEN_W-1:0] Reg0 = GEN_W'(R0);
    localparam logic [GEN_W-1:0] Reg1 = GEN_W'(R1);

    logic           e00;
    logic           e01;
    logic           e10;
    logic           e11;
    logic [1:0]     bm0;
    logic [1:0]     bm1;
    logic [SumW-1:0] sum0;
    logic [SumW-1:0] sum1;
    logic [MW-1:0]  m0;
    logic [MW-1:0]  m1;
    logic           pick_low;

    assign pm_in[s] = sym.frame_start ? ((s == 0) ? '0 : Far) : pm[s];

    assign e00 = ^(Reg0 & gen_zero);
    assign e01 = ^(Reg0 & gen_one);
    assign e10 = ^(Reg1 & gen_zero);
    assign e11 = ^(Reg1 & gen_one);
    assign bm0 = {1'b0, e00 ^ sym.code_bit_zero} + {1'b0, e01 ^ sym.code_bit_one};
    assign bm1 = {1'b0, e10 ^ sym.code_bit_zero} + {1'b0, e11 ^ sym.code_bit_one};
    assign sum0 = {1'b0, pm_in[P0]} + SumW'(bm0);
    assign sum1 = {1'b0, pm_in[P1]} + SumW'(bm1);
    assign m0 = sum0[MW] ? '1 : sum0[MW-1:0];
    assign m1 = sum1[MW] ? '1 : sum1[MW-1:0];
    // ties go to the lower parent
    assign pick_low   = (m0 <= m1);
    assign pm_new[s]  = pick_low ? m0 : m1;
    assign surv_col[s] = !pick_low;
  end

  assign wr_base   = sym.frame_start ? '0 : wr_slot;
  assign seen_base = sym.frame_start ? '0 : seen;

  // survivor columns
  always_ff @(posedge clk) begin
    if (start) begin
      surv_mem[wr_base] <= surv_col;
    end
  end

  always_ff @(posedge clk) begin
    surv_rd <= surv_mem[col];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sym_pop      = 1'b0;
    start        = 1'b0;
    res_push     = 1'b0;
    wr_slot_next = wr_slot;
    seen_next    = seen;
    col_next     = col;
    step_next    = step;
    tbs_next     = tbs;
    res_next     = res;
    case (state)
      BK_IDLE: begin
        if (sym_vld) begin
          sym_pop      = 1'b1;
          start        = 1'b1;
          wr_slot_next = (wr_base == LastCol) ? '0 : wr_base + CW'(1);
          col_next     = wr_base;
          step_next    = '0;
          tbs_next     = '0;
          if (seen_base == LastCol) begin
            seen_next  = seen_base;
            state_next = BK_TRACE;
          end else begin
            seen_next  = seen_base + CW'(1);
          end
        end
      end
      BK_TRACE: begin
        col_next  = (col == '0) ? LastCol : col - CW'(1);
        step_next = step + CW'(1);
        if (step != '0) begin
          tbs_next = {surv_rd[tbs], tbs[SW-1:1]};
        end
        if (step == LastCol) begin
          res_next   = tbs_next[0];
          state_next = BK_PUSH;
        end
      end
      BK_PUSH: begin
        if (res_ready) begin
          res_push   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_slot <= '0;
      seen    <= '0;
      for (int i = 0; i < NS; i++) begin
        pm[i] <= (i == 0) ? '0 : Far;
      end
    end else begin
      wr_slot <= wr_slot_next;
      seen    <= seen_next;
      if (start) begin
        for (int i = 0; i < NS; i++) begin
          pm[i] <= pm_new[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    col  <= col_next;
    step <= step_next;
    tbs  <= tbs_next;
    res  <= res_next;
  end

  assign res_bit = res;

endmodule
`default_nettype wire

>>> rtl/viterbi_hard_decision_decoder.sv
// an item with no result leaves the back end after its add-compare-select step; one that
// yields a bit holds the back end through the IDLE, TRACE and PUSH states, and PUSH waits
// for room in the result register, which it then loads; the back end takes no new item
// meanwhile, and the traceback walks back one column per cycle over the survivor memory;
// reset empties the queues, zeroes the counters,
// sets generators 7 and 5 and metrics zero for state 0, unreachable elsewhere; survivors kept
`timescale 1ns / 1ps
`default_nettype none
`include "viterbi_hard_decision_decoder_assert.svh"
module viterbi_hard_decision_decoder
  import vhd_pkg::*;
#(
  parameter int CONSTRAINT_LENGTH = 3,
  parameter int TRACEBACK_DEPTH   = 6,
  parameter int METRIC_WIDTH      = 16
) (
  input  wire  logic                 clk,
  input  wire  logic                 rst,
  input  wire  logic                 push,
  output logic                       full,
  input  wire  logic                 code_bit_zero,
  input  wire  logic                 code_bit_one,
  input  wire  logic                 frame_start,
  output logic                       empty,
  input  wire  logic                 pop,
  output logic                       decoded_bit,
  input  wire  logic                 cfg_valid,
  output logic                       cfg_ready,
  input  wire  logic [CFG_IDX_W-1:0] cfg_index,
  input  wire  logic [GEN_W-1:0]     cfg_data
);

  logic [GEN_W-1:0] gen_zero;
  logic [GEN_W-1:0] gen_one;
  sym_t             in_sym;
  sym_t             sym;
  logic             sym_vld;
  logic             sym_pop;
  logic             res_ready;
  logic             res_push;
  logic             res_bit;
  logic             out_vld;
  logic             out_bit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_zero <= GEN_ZERO_RESET;
      gen_one  <= GEN_ONE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GEN_ZERO: gen_zero <= cfg_data;
        CFG_GEN_ONE:  gen_one  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_sym = '{code_bit_zero: code_bit_zero,
                    code_bit_one:  code_bit_one,
                    frame_start:   frame_start};

  vhd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .in_sym  (in_sym),
    .sym_vld (sym_vld),
    .sym     (sym),
    .sym_pop (sym_pop)
  );

  vhd_back #(
    .CONSTRAINT_LENGTH (CONSTRAINT_LENGTH),
    .TRACEBACK_DEPTH   (TRACEBACK_DEPTH),
    .METRIC_WIDTH      (METRIC_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .gen_zero  (gen_zero),
    .gen_one   (gen_one),
    .sym_vld   (sym_vld),
    .sym       (sym),
    .sym_pop   (sym_pop),
    .res_ready (res_ready),
    .res_push  (res_push),
    .res_bit   (res_bit)
  );

  // result register
  assign res_ready = !out_vld || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (res_push) begin
      out_vld <= 1'b1;
    end else if (pop) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_bit <= res_bit;
    end
  end

  assign empty       = !out_vld;
  assign decoded_bit = out_bit;

  `VHD_ASSERT_NOW(a_no_overwrite, res_push, !out_vld || pop)
  `VHD_ASSERT_NEXT(a_result_shown, res_push, !empty)
  `VHD_ASSERT_NEXT(a_item_queued, push && !full, sym_vld)
  `VHD_ASSERT_NOW(a_pop_has_item, sym_pop, sym_vld)

endmodule
`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import vhd_pkg::*;

  localparam int K = 3;
  localparam int DEPTH = 6;
  localparam int MW = 16;
  localparam int NSTATES = 1 << (K - 1);
  localparam int TOP_BIT = NSTATES >> 1;
  localparam logic [MW-1:0] METRIC_FULL = {MW{1'b1}};
  localparam logic [MW-1:0] FAR_METRIC =
    (UNREACHABLE_SEED > 64'(METRIC_FULL)) ? METRIC_FULL : MW'(UNREACHABLE_SEED);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_TWO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_THREE = 2'd3;
  localparam int DRAIN_CYCLES = 20;
  localparam int RX_STALL_CYCLES = 600;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic code_bit_zero = 1'b0;
  logic code_bit_one = 1'b0;
  logic frame_start = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic decoded_bit;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GEN_W-1:0] cfg_data = '0;

  viterbi_hard_decision_decoder dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .code_bit_zero(code_bit_zero), .code_bit_one(code_bit_one), .frame_start(frame_start),
    .empty(empty), .pop(pop), .decoded_bit(decoded_bit),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("timeout at %0t", $time);
    $display("status: fail");
    $finish;
  end

  // decoder mirror
  logic [MW-1:0] metric [2][NSTATES];
  logic survivor [DEPTH][NSTATES];
  int write_col;
  int bank;
  int warm_count;
  logic [GEN_W-1:0] gen_zero = GEN_ZERO_RESET;
  logic [GEN_W-1:0] gen_one = GEN_ONE_RESET;

  logic decoded_bits_due [$];
  sym_t pending [$];
  logic [K-1:0] enc_reg = '0;

  int fail_count = 0;
  int items_sent = 0;
  int frames_started = 0;
  int results_checked = 0;
  int cfg_writes = 0;

  sym_t tx_item;
  int tx_gap = 0;
  bit tx_steady = 1'b0;
  int rx_wait = 0;
  bit rx_steady = 1'b0;
  bit rx_stall_req = 1'b0;
  bit rx_stall_done = 1'b0;
  int rx_stall_left = 0;
  logic exp_bit;

  function automatic void clear_trellis();
    for (int s = 0; s < NSTATES; s++) begin
      metric[0][s] = (s == 0) ? '0 : FAR_METRIC;
      metric[1][s] = (s == 0) ? '0 : FAR_METRIC;
      for (int c = 0; c < DEPTH; c++) survivor[c][s] = 1'b0;
    end
    write_col = 0;
    bank = 0;
    warm_count = 0;
  endfunction

  function automatic logic [MW-1:0] sat_add(input logic [MW-1:0] a, input int b);
    int sum;
    sum = int'(a) + b;
    return (sum > int'(METRIC_FULL)) ? METRIC_FULL : MW'(sum);
  endfunction

  function automatic int branch_cost(input logic [K-1:0] r, input sym_t s);
    return int'((^(r & gen_zero)) ^ s.code_bit_zero) + int'((^(r & gen_one)) ^ s.code_bit_one);
  endfunction

  // add-compare-select, then traceback once the window is full
  function automatic void decode_symbol(input sym_t s);
    int prv, cur, p0, p1, st, col;
    logic [K-1:0] r0, r1;
    logic [MW-1:0] m0, m1;
    if (s.frame_start) clear_trellis();
    prv = bank;
    cur = prv ^ 1;
    for (int t = 0; t < NSTATES; t++) begin
      p0 = t >> 1;
      p1 = p0 | TOP_BIT;
      r0 = K'((p0 << 1) | (t & 1));
      r1 = K'((p1 << 1) | (t & 1));
      m0 = sat_add(metric[prv][p0], branch_cost(r0, s));
      m1 = sat_add(metric[prv][p1], branch_cost(r1, s));
      if (m0 <= m1) begin
        metric[cur][t] = m0;
        survivor[write_col][t] = 1'b0;
      end else begin
        metric[cur][t] = m1;
        survivor[write_col][t] = 1'b1;
      end
    end
    bank = cur;
    write_col = (write_col + 1 >= DEPTH) ? 0 : write_col + 1;
    if (warm_count >= DEPTH - 1) begin
      st = 0;
      col = (write_col == 0) ? DEPTH - 1 : write_col - 1;
      for (int k = 0; k + 1 < DEPTH; k++) begin
        st = (st >> 1) | (survivor[col][st] ? TOP_BIT : 0);
        col = (col == 0) ? DEPTH - 1 : col - 1;
      end
      decoded_bits_due.push_back(st[0]);
    end else begin
      warm_count++;
    end
  endfunction

  function automatic sym_t symbol_of(input logic b0, input logic b1, input logic fs);
    sym_t s;
    s.code_bit_zero = b0;
    s.code_bit_one = b1;
    s.frame_start = fs;
    return s;
  endfunction

  // encoder with the current generators, about one flipped bit in ten
  function automatic sym_t encoded_symbol(input logic info, input logic fs);
    logic y0, y1;
    if (fs) enc_reg = '0;
    enc_reg = {enc_reg[K-2:0], info};
    y0 = (^(enc_reg & gen_zero)) ^ ($urandom_range(0, 9) == 0);
    y1 = (^(enc_reg & gen_one)) ^ ($urandom_range(0, 9) == 0);
    return symbol_of(y0, y1, fs);
  endfunction

  task automatic queue_frames(input int n);
    int left, len, kind;
    logic fs;
    left = n;
    while (left > 0) begin
      kind = $urandom_range(0, 19);
      len = (kind < 2) ? $urandom_range(1, DEPTH) : $urandom_range(DEPTH + 1, 60);
      if (len > left) len = left;
      for (int i = 0; i < len; i++) begin
        fs = (i == 0) && (kind < 18);
        if (kind >= 15 && kind <= 17)
          pending.push_back(symbol_of(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), fs));
        else
          pending.push_back(encoded_symbol(1'($urandom_range(0, 1)), fs));
      end
      left -= len;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GEN_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_GEN_ZERO) gen_zero = val;
    else if (idx == CFG_GEN_ONE) gen_one = val;
    cfg_writes++;
  endtask

  task automatic wait_until_drained();
    while (pending.size() > 0 || push || decoded_bits_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // item driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      tx_gap = 0;
    end else begin
      if (push && !full) begin
        decode_symbol(tx_item);
        items_sent++;
        if (tx_item.frame_start) frames_started++;
        if ($urandom_range(0, 63) == 0) tx_steady = !tx_steady;
        tx_gap = tx_steady ? 0 : $urandom_range(0, 16);
      end
      if (!(push && full)) begin
        if (tx_gap > 0) begin
          tx_gap--;
          push <= 1'b0;
        end else if (pending.size() > 0) begin
          tx_item = pending.pop_front();
          push <= 1'b1;
          code_bit_zero <= tx_item.code_bit_zero;
          code_bit_one <= tx_item.code_bit_one;
          frame_start <= tx_item.frame_start;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      rx_wait = 0;
    end else begin
      if (pop && !empty) begin
        if (decoded_bits_due.size() == 0) begin
          fail_count++;
          if (fail_count < 50)
            $display("%0t: decoded_bit with none expected, actual %0b", $time, decoded_bit);
        end else begin
          exp_bit = decoded_bits_due.pop_front();
          if (decoded_bit !== exp_bit) begin
            fail_count++;
            if (fail_count < 50)
              $display("%0t: decoded_bit expected %0b actual %0b", $time, exp_bit, decoded_bit);
          end
        end
        results_checked++;
        if ($urandom_range(0, 63) == 0) rx_steady = !rx_steady;
        rx_wait = rx_steady ? 0 : $urandom_range(0, 16);
      end
      if (rx_stall_req && !rx_stall_done) begin
        rx_stall_left = RX_STALL_CYCLES;
        rx_stall_done = 1'b1;
      end
      if (rx_stall_left > 0) begin
        rx_stall_left--;
        pop <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  logic [2:0] directed [19] = '{
    3'b001, 3'b110, 3'b100, 3'b010, 3'b000, 3'b110, 3'b010, 3'b100,
    3'b111, 3'b000, 3'b100, 3'b001,
    3'b110, 3'b010, 3'b100, 3'b110, 3'b000, 3'b010, 3'b111
  };
  logic [GEN_W-1:0] zero_list [5] = '{3'd0, 3'd7, 3'd3, 3'd5, 3'd1};
  logic [GEN_W-1:0] one_list [5] = '{3'd0, 3'd7, 3'd6, 3'd7, 3'd2};

  initial begin
    clear_trellis();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    write_reg(CFG_GEN_ZERO, GEN_ZERO_RESET);
    write_reg(CFG_GEN_ONE, GEN_ONE_RESET);
    // restarts after results and in the middle of warm-up
    foreach (directed[i]) pending.push_back(sym_t'(directed[i]));
    for (int ph = 0; ph < 5; ph++) begin
      wait_until_drained();
      write_reg(CFG_GEN_ZERO, zero_list[ph]);
      write_reg(CFG_GEN_ONE, one_list[ph]);
      if (ph == 1) begin
        write_reg(CFG_SPARE_TWO, 3'd2);
        write_reg(CFG_SPARE_THREE, 3'd6);
        rx_stall_req = 1'b1;
      end
      queue_frames(376);
    end
    wait_until_drained();
    $display("covered %0d symbols in %0d frames, %0d decoded bits checked, %0d register writes",
             items_sent, frames_started, results_checked, cfg_writes);
    $display("generator pairs from 0/0 to 7/7, long result stall and sender drain pauses");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
